@@ hw/rtl/i2a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared widths, operation codes, character constants and the control and
// status structs that pass between the sequencer and the digit register.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Field widths.
  localparam int NUM_W   = 64;
  localparam int DEC_W   = 32;
  localparam int COUNT_W = 31;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W   = 4 * BCD_DIGITS;
  localparam int DCNT_W  = 5;

  // Operation codes.
  localparam logic [1:0] OP_PTR  = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_UDEC = 2'd2;

  // Characters.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // Number of digit positions loaded into the digit register.
  localparam logic [DCNT_W-1:0] HEX_LEN = 5'd16;
  localparam logic [DCNT_W-1:0] DEC_LEN = 5'd10;

  // Saturation limit of the running character count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7fff_ffff;

  // Digit value to lower-case ASCII.
  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // Commands to the digit register.
  typedef struct packed {
    logic              load;
    logic              shift;
    logic [NUM_W-1:0]  value;
    logic [DCNT_W-1:0] count;
  } digit_ctrl_t;

  // Status of the digit register.
  typedef struct packed {
    logic [3:0] nibble;
    logic       final_digit;
    logic       lead_zero;
  } digit_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/i2a_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter channels
// Valid/ready channels for the number requests and the character requests.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] number;
  logic        restart_count;

  modport source (output valid, op, number, restart_count, input ready);
  modport sink   (input valid, op, number, restart_count, output ready);
endinterface

interface i2a_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  character;
  logic        last;
  logic [30:0] total_count;

  modport source (output valid, character, last, total_count, input ready);
  modport sink   (input valid, character, last, total_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/i2a_bcd.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-three conversion of a 32-bit value into ten BCD digits,
// two input bits per cycle.
// ----------------------------------------------------------------------------
module i2a_bcd import i2a_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DEC_W-1:0] value,
  output logic                  done,
  output logic [BCD_W-1:0]      bcd
);

  localparam int STEP_W = $clog2(DEC_W / 2);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DEC_W / 2 - 1);

  logic [DEC_W-1:0]  bin;
  logic [STEP_W-1:0] step;
  logic              running;

  // One conversion step: correct each digit that would overflow, then shift.
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] d,
                                              input logic b);
    logic [BCD_W-1:0] a;
    a = d;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (a[4*i +: 4] >= 4'd5) begin
        a[4*i +: 4] = a[4*i +: 4] + 4'd3;
      end
    end
    return {a[BCD_W-2:0], b};
  endfunction

  // Control of the step sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      step    <= '0;
    end else if (running) begin
      step <= step + 1'b1;
      if (step == STEP_LAST) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Data shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (running) begin
      bin <= {bin[DEC_W-3:0], 2'b00};
      bcd <= dabble(dabble(bcd, bin[DEC_W-1]), bin[DEC_W-2]);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/i2a_digits.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Digit shift register
// Holds the digits of the value, most significant at the top, and shifts
// one 4-bit digit out per step.
// ----------------------------------------------------------------------------
module i2a_digits import i2a_pkg::*; (
  input  wire logic        clk,
  input  wire digit_ctrl_t ctrl,
  output digit_stat_t      stat
);

  logic [NUM_W-1:0]  word;
  logic [DCNT_W-1:0] left;

  // Load or shift the digit word.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= ctrl.value;
      left <= ctrl.count;
    end else if (ctrl.shift) begin
      word <= {word[NUM_W-5:0], 4'h0};
      left <= left - 1'b1;
    end
  end

  // The top digit and whether it is the last one or a leading zero.
  assign stat.nibble      = word[NUM_W-1 -: 4];
  assign stat.final_digit = (left == DCNT_W'(1));
  assign stat.lead_zero   = (word[NUM_W-1 -: 4] == 4'h0) && (left > DCNT_W'(1));

endmodule
`default_nettype wire

@@ hw/rtl/integer_to_ascii_formatter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// The item channel takes a number, a mode and a count restart flag; the text
// channel returns one ASCII character per request, most significant first,
// with last set on the final character and the saturating running count.
// One item is handled at a time; item.ready is high only while idle.
// Hex mode: "0x" goes out first, then leading zeros are dropped (the last
// digit is always kept), the skip state hands off to emission and one digit
// goes out per cycle while the receiver takes them. Decimal modes: the
// optional '-' goes out while a two-bits-per-cycle BCD converter runs; its
// result is then loaded into the digit register, leading zeros are dropped,
// the skip state hands off and one digit goes out per cycle while the
// receiver takes them. The scan always walks every digit position; an
// unknown mode leaves the block idle.
// A registered output stage holds a character while the receiver stalls;
// the sequencer waits and nothing is lost. An unknown mode emits nothing.
// Synchronous reset returns to idle, empties the output stage and clears
// the running count.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top import i2a_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  i2a_in_if.sink      item,
  i2a_out_if.source   text
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREFIX = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_SKIP   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic               is_ptr;
  logic               pre_idx;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_inc;

  logic               out_valid;
  logic [7:0]         out_char;
  logic               out_last;
  logic [COUNT_W-1:0] out_total;

  logic               accept;
  logic               out_free;
  logic               emit_fire;
  logic [7:0]         emit_char;
  logic               emit_last;
  logic               prefix_done;

  logic               neg;
  logic [DEC_W-1:0]   low;
  logic [DEC_W-1:0]   mag;
  logic               bcd_start;
  logic               bcd_done;
  logic [BCD_W-1:0]   bcd;

  digit_ctrl_t        dctrl;
  digit_stat_t        dstat;

  // Handshake and output stage availability.
  assign item.ready = (state == S_IDLE) && !rst;
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || text.ready;
  assign emit_fire  = out_free && ((state == S_PREFIX) || (state == S_EMIT));

  // Decimal operand preparation.
  assign low       = item.number[DEC_W-1:0];
  assign neg       = (item.op == OP_SDEC) && low[DEC_W-1];
  assign mag       = neg ? (DEC_W'(0) - low) : low;
  assign bcd_start = accept && ((item.op == OP_SDEC) || (item.op == OP_UDEC));

  i2a_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .value (mag),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  // Digit register commands.
  always_comb begin
    dctrl.load  = (accept && (item.op == OP_PTR)) || ((state == S_WAIT) && bcd_done);
    dctrl.shift = ((state == S_SKIP) && dstat.lead_zero) ||
                  ((state == S_EMIT) && emit_fire);
    if (state == S_IDLE) begin
      dctrl.value = item.number;
      dctrl.count = HEX_LEN;
    end else begin
      dctrl.value = {bcd, {(NUM_W - BCD_W){1'b0}}};
      dctrl.count = DEC_LEN;
    end
  end

  i2a_digits u_digits (
    .clk  (clk),
    .ctrl (dctrl),
    .stat (dstat)
  );

  // Character selection.
  always_comb begin
    if (state == S_PREFIX) begin
      emit_char = is_ptr ? (pre_idx ? CHAR_X : CHAR_ZERO) : CHAR_MINUS;
      emit_last = 1'b0;
    end else begin
      emit_char = HEX_CHARS[dstat.nibble];
      emit_last = dstat.final_digit;
    end
  end

  assign prefix_done = !is_ptr || pre_idx;
  assign count_inc   = (count == COUNT_MAX) ? count : count + 1'b1;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.op == OP_PTR || neg) begin
            state_next = S_PREFIX;
          end else if (item.op == OP_UDEC || item.op == OP_SDEC) begin
            state_next = S_WAIT;
          end
        end
      end
      S_PREFIX: begin
        if (emit_fire && prefix_done) begin
          state_next = is_ptr ? S_SKIP : S_WAIT;
        end
      end
      S_WAIT: begin
        if (bcd_done) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (!dstat.lead_zero) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire && dstat.final_digit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer and running count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      is_ptr  <= 1'b0;
      pre_idx <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        is_ptr  <= (item.op == OP_PTR);
        pre_idx <= 1'b0;
        if (item.restart_count) begin
          count <= '0;
        end
      end else if (emit_fire) begin
        count <= count_inc;
        if (state == S_PREFIX) begin
          pre_idx <= 1'b1;
        end
      end
    end
  end

  // Output stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_char  <= emit_char;
      out_last  <= emit_last;
      out_total <= count_inc;
    end
  end

  assign text.valid       = out_valid;
  assign text.character   = out_char;
  assign text.last        = out_last;
  assign text.total_count = out_total;

`ifndef NO_ASSERTIONS
  // The final digit ends the item and leaves a last-marked request waiting.
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_fire && dstat.final_digit) |=>
      (state == S_IDLE && out_valid && out_last))
    else $error("final digit did not end the item");

  // Below saturation each character advances the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && count != COUNT_MAX) |=> (count == $past(count) + 1'b1))
    else $error("running count did not advance by one");

  // A restart request clears the count.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && item.restart_count) |=> (count == '0))
    else $error("restart did not clear the running count");

  // The reported count always matches the running count after the emission.
  a_total_match: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (out_total == count))
    else $error("reported count differs from running count");
`endif

endmodule
`default_nettype wire

@@ tb/integer_to_ascii_formatter_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter testbench
// Sends number requests in all three conversion modes plus the unused mode,
// predicts every character request with its last flag and running count,
// and checks the text channel in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top_tb;
  import i2a_pkg::*;

  // Mode code that the block ignores.
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int RANDOM_ITEMS  = 260;
  localparam int IDLE_PCT      = 21;
  localparam int STALL_AT_ITEM = 40;
  localparam int STALL_CYCLES  = 400;
  localparam int CALM_FROM     = 3000;
  localparam int CALM_TO       = 5000;
  localparam int TAIL_CYCLES   = 64;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] number;
    logic        restart;
    bit          drain_first;
  } num_req_t;

  typedef struct {
    logic [7:0]         character;
    logic               last;
    logic [COUNT_W-1:0] total_count;
  } char_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  i2a_in_if  item_ch ();
  i2a_out_if text_ch ();

  integer_to_ascii_formatter_top dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .text (text_ch)
  );

  num_req_t           pending [$];
  char_req_t          expected_text [$];
  logic [COUNT_W-1:0] char_count;
  int                 items_offered = 0;
  int                 items_taken = 0;
  int                 chars_checked = 0;
  int                 fail_count = 0;
  int                 cycle_no = 0;
  int                 mode_seen [4] = '{0, 0, 0, 0};
  int                 stall_left = 0;
  bit                 stall_done = 1'b0;

  // Stretch of the run in which neither side idles at random.
  wire calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Builds one number request.
  function automatic num_req_t number_req(input logic [1:0] op, input logic [63:0] num,
                                          input logic restart);
    num_req_t r;
    r.op = op;
    r.number = num;
    r.restart = restart;
    r.drain_first = 1'b0;
    return r;
  endfunction

  // Formats one number and queues the characters it should produce.
  task automatic predict_text(input logic [1:0] op, input logic [63:0] num,
                              input logic restart);
    logic [7:0]  chars [$];
    logic [7:0]  digits [$];
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] d;
    logic [31:0] low;
    char_req_t   exp_char;
    if (restart) char_count = '0;
    case (op)
      OP_PTR: begin
        chars.push_back(CHAR_ZERO);
        chars.push_back(CHAR_X);
        mag = num;
        radix = 64'd16;
      end
      OP_SDEC: begin
        low = num[31:0];
        if (low[31]) begin
          chars.push_back(CHAR_MINUS);
          // Negation of the most negative value wraps back to its magnitude.
          low = 32'd0 - low;
        end
        mag = {32'd0, low};
        radix = 64'd10;
      end
      OP_UDEC: begin
        mag = {32'd0, num[31:0]};
        radix = 64'd10;
      end
      default: return;
    endcase
    // Least significant digit first, so each new digit goes to the front.
    do begin
      d = mag % radix;
      digits.push_front((d < 64'd10) ? CHAR_ZERO + d[7:0] : 8'h61 + d[7:0] - 8'd10);
      mag = mag / radix;
    end while (mag != 64'd0);
    chars = {chars, digits};
    foreach (chars[k]) begin
      if (char_count != COUNT_MAX) char_count = char_count + 1'b1;
      exp_char.character = chars[k];
      exp_char.last = (k == chars.size() - 1);
      exp_char.total_count = char_count;
      expected_text.push_back(exp_char);
    end
  endtask

  // Predict on every accepted number request.
  always @(posedge clk) begin
    if (rst) begin
      char_count = '0;
    end else if (item_ch.valid && item_ch.ready) begin
      predict_text(item_ch.op, item_ch.number, item_ch.restart_count);
      mode_seen[item_ch.op] <= mode_seen[item_ch.op] + 1;
      items_taken <= items_taken + 1;
    end
  end

  // Number request driver, fed from the pending queue.
  always @(negedge clk) begin
    num_req_t next;
    logic     busy;
    logic     hold;
    if (!rst) begin
      busy = item_ch.valid && (items_taken != items_offered);
      if (!busy) begin
        hold = (pending.size() == 0);
        if (!hold && pending[0].drain_first) hold = (expected_text.size() != 0);
        if (!hold && !calm && ($urandom_range(0, 99) < IDLE_PCT)) hold = 1'b1;
        if (hold) begin
          item_ch.valid <= 1'b0;
          item_ch.op <= 2'($urandom);
          item_ch.number <= {$urandom, $urandom};
          item_ch.restart_count <= 1'($urandom);
        end else begin
          next = pending.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.op <= next.op;
          item_ch.number <= next.number;
          item_ch.restart_count <= next.restart;
          items_offered <= items_offered + 1;
        end
      end
    end
  end

  // Character request ready, with one long hold-off to back up the block.
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left != 0) begin
        text_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!stall_done && (items_taken >= STALL_AT_ITEM)) begin
        stall_done <= 1'b1;
        stall_left <= STALL_CYCLES;
        text_ch.ready <= 1'b0;
      end else begin
        text_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare each accepted character request with the oldest prediction.
  always @(posedge clk) begin
    char_req_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (expected_text.size() == 0) begin
        $error("character request with nothing expected: character %h", text_ch.character);
        fail_count++;
      end else begin
        want = expected_text.pop_front();
        chars_checked++;
        if (text_ch.character !== want.character) begin
          $error("character: expected %h, actual %h", want.character, text_ch.character);
          fail_count++;
        end
        if (text_ch.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, text_ch.last);
          fail_count++;
        end
        if (text_ch.total_count !== want.total_count) begin
          $error("total_count: expected %0d, actual %0d", want.total_count,
                 text_ch.total_count);
          fail_count++;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    num_req_t r;
    int       sel;
    item_ch.valid = 1'b0;
    item_ch.op = OP_PTR;
    item_ch.number = '0;
    item_ch.restart_count = 1'b0;
    text_ch.ready = 1'b0;

    // Directed: field extremes, every mode, zero, the most negative value.
    pending.push_back(number_req(OP_PTR,  64'd0, 1'b0));
    pending.push_back(number_req(OP_PTR,  64'hffff_ffff_ffff_ffff, 1'b0));
    pending.push_back(number_req(OP_PTR,  64'd1, 1'b0));
    pending.push_back(number_req(OP_PTR,  64'h8000_0000_0000_0000, 1'b0));
    pending.push_back(number_req(OP_PTR,  64'h0123_4567_89ab_cdef, 1'b0));
    pending.push_back(number_req(OP_SDEC, 64'd0, 1'b0));
    pending.push_back(number_req(OP_SDEC, 64'h0000_0000_8000_0000, 1'b0));
    pending.push_back(number_req(OP_SDEC, 64'h0000_0000_7fff_ffff, 1'b0));
    pending.push_back(number_req(OP_SDEC, 64'hffff_ffff_ffff_ffff, 1'b0));
    pending.push_back(number_req(OP_SDEC, 64'hdead_beef_0000_0005, 1'b0));
    pending.push_back(number_req(OP_SDEC, 64'd9, 1'b1));
    pending.push_back(number_req(OP_UDEC, 64'd0, 1'b0));
    pending.push_back(number_req(OP_UDEC, 64'h0000_0000_ffff_ffff, 1'b0));
    pending.push_back(number_req(OP_UDEC, 64'hffff_ffff_0000_000a, 1'b0));
    pending.push_back(number_req(OP_UDEC, 64'd1000000000, 1'b0));
    pending.push_back(number_req(OP_NONE, 64'h1234, 1'b0));
    pending.push_back(number_req(OP_UDEC, 64'd7, 1'b0));
    pending.push_back(number_req(OP_NONE, 64'hffff_ffff_ffff_ffff, 1'b1));
    pending.push_back(number_req(OP_PTR,  64'hf, 1'b0));
    pending.push_back(number_req(OP_PTR,  64'h10, 1'b1));

    // Random: mostly valid modes, sizes from one digit to full width.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 9);
      r.op = (sel < 3) ? OP_PTR : (sel < 6) ? OP_SDEC : (sel < 9) ? OP_UDEC : OP_NONE;
      r.number = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: ;
        1: r.number = r.number >> $urandom_range(0, 63);
        2: r.number[31:0] = $urandom_range(0, 20);
        default: begin
          if ($urandom_range(0, 1)) r.number[31:0] = 32'h8000_0000 ^ $urandom_range(0, 15);
          else r.number[31:0] = ~32'($urandom_range(0, 20));
        end
      endcase
      r.restart = ($urandom_range(0, 9) == 0);
      // Let the block drain completely before these.
      r.drain_first = (n == 0) || (n == RANDOM_ITEMS / 2);
      pending.push_back(r);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || items_taken != items_offered) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d pointer, %0d signed, %0d unsigned, %0d unused mode.",
             items_taken, mode_seen[OP_PTR], mode_seen[OP_SDEC], mode_seen[OP_UDEC],
             mode_seen[OP_NONE]);
    $display("Checked %0d characters with last flag and running count.", chars_checked);
    if (fail_count == 0) begin
      $display("PASS integer_to_ascii_formatter_top");
    end else begin
      $display("FAIL integer_to_ascii_formatter_top");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("FAIL integer_to_ascii_formatter_top");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_if.sv
hw/rtl/i2a_bcd.sv
hw/rtl/i2a_digits.sv
hw/rtl/integer_to_ascii_formatter_top.sv
tb/integer_to_ascii_formatter_top_tb.sv
